/* design/pes_pkg.sv */
// Shared types, constants and helper functions for the particle emitter step core.
// Depends on nothing; imported by particle_emitter_step_core, the checker and the testbench top.
`timescale 1ns / 1ps

package pes_pkg;

  // Q16.16 representation of the damping slope 0.6.
  localparam logic [17:0] DAMP_COEF  = 18'd39322;
  localparam logic [16:0] JIT_ONE    = 17'd65535;
  localparam logic [16:0] JIT_TWO    = 17'd131070;
  localparam logic [31:0] AGE_MAX    = 32'hFFFF_FFFF;
  localparam int          CREDIT_DIV_STEPS = 32;
  localparam int          SCALE_DIV_STEPS  = 16;

  typedef enum logic [2:0] {
    REG_SPAWN_INTERVAL = 3'd0,
    REG_LIFETIME       = 3'd1,
    REG_VEL_JITTER     = 3'd2,
    REG_EMITTER_POS    = 3'd3,
    REG_BASE_VEL       = 3'd4,
    REG_START_SCALE    = 3'd5,
    REG_RANDOM_SEED    = 3'd6,
    REG_UNUSED         = 3'd7
  } reg_index_t;

  // One stored particle; component 0 of each vector is x.
  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][15:0] vel;
    logic [31:0]      age;
  } particle_t;

  function automatic logic [15:0] sat16(input logic signed [51:0] x);
    if (x > 52'sd32767) begin
      return 16'h7FFF;
    end else if (x < -52'sd32768) begin
      return 16'h8000;
    end else begin
      return x[15:0];
    end
  endfunction

  // Rounds a Q.16 product to an integer, halves going up.
  function automatic logic signed [51:0] round_q16(input logic signed [51:0] x);
    logic signed [51:0] s;
    s = x + 52'sd32768;
    return s >>> 16;
  endfunction

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

/* design/particle_emitter_step_core.sv */
// Particle emitter step core: sequencer, shared multiplier and divider, particle store.
// Depends on pes_pkg.
`timescale 1ns / 1ps

// Each accepted word is one time tick. The core spawns particles from the spawn
// credit, integrates every live particle and then sends one result word per visible
// particle (or a single none_visible word), the final one flagged with last. Work is
// done by one multiplier and one radix-2 divider under a sequencer, and in_stall stays
// high for the whole tick. The credit division runs 32 steps and the scale division 16
// steps per particle, and the store gives one registered read a cycle. Results may wait
// in the output register while the next tick is accepted.
module particle_emitter_step_core #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [16:0]        in_delta_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [15:0]        out_render_scale,
  output logic [6:0]         out_live_count,
  output logic               out_none_visible,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_wdata
);
  import pes_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_CDIV  = 20'h00002,
    S_DAMP  = 20'h00004,
    S_DAMP2 = 20'h00008,
    S_SPCHK = 20'h00010,
    S_JMUL  = 20'h00020,
    S_JFIN  = 20'h00040,
    S_SPWR  = 20'h00080,
    S_URD   = 20'h00100,
    S_ULD   = 20'h00200,
    S_UM1   = 20'h00400,
    S_UM2   = 20'h00800,
    S_UM3   = 20'h01000,
    S_UWR   = 20'h02000,
    S_ERD   = 20'h04000,
    S_EMUL  = 20'h08000,
    S_ELD   = 20'h10000,
    S_EDIV  = 20'h20000,
    S_EOUT  = 20'h40000,
    S_FINAL = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [31:0] cfg_interval_r, cfg_life_r;
  logic [15:0] cfg_jitter_r, cfg_scale_r;
  logic [47:0] cfg_emit_r, cfg_base_r;

  // Tick state.
  logic [31:0]        rng_r, credit_r, due_r;
  logic [CW-1:0]      alive_r, kept_r, i_r;
  logic [16:0]        dt_r;
  logic signed [17:0] damp_r, jx_r, jz_r;
  logic               jsel_r;
  logic [1:0]         k_r;
  particle_t          wk_r, rd_data_r;
  logic signed [51:0] prod_r;

  // Divider.
  logic [31:0] div_rem_r, div_q_r, div_d_r;
  logic [5:0]  div_cnt_r;

  // Pending visible particle, held until it is known whether another follows.
  logic             pend_valid_r;
  logic [2:0][15:0] pend_pos_r;
  logic [15:0]      pend_scale_r;

  // Output register.
  logic             out_valid_r, out_none_r, out_last_r;
  logic [2:0][15:0] out_pos_r;
  logic [15:0]      out_scale_r;
  logic [6:0]       out_live_r;

  particle_t mem [MAX_PARTICLES];

  // ---------------------------------------------------------------------------
  // Shared multiplier.
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [17:0] jit_t;
  logic [1:0]         k_idx;
  logic [15:0]        vel_sel;
  logic [31:0]        life_left;

  assign jit_t     = $signed({1'b0, rng_r[31:16], 1'b0}) - $signed({1'b0, JIT_ONE});
  assign k_idx     = (state_r == S_UM3 && k_r != 2'd2) ? k_r + 2'd1 : k_r;
  assign vel_sel   = wk_r.vel[k_idx];
  assign life_left = cfg_life_r - rd_data_r.age;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DAMP: begin
        mul_a = $signed(DAMP_COEF);
        mul_b = $signed({17'b0, dt_r});
      end
      S_JMUL: begin
        mul_a = jit_t;
        mul_b = $signed({18'b0, cfg_jitter_r});
      end
      S_UM1, S_UM3: begin
        mul_a = $signed({{2{vel_sel[15]}}, vel_sel});
        mul_b = $signed({17'b0, dt_r});
      end
      S_UM2: begin
        mul_a = damp_r;
        mul_b = $signed({{18{vel_sel[15]}}, vel_sel});
      end
      S_EMUL: begin
        mul_a = $signed({2'b0, cfg_scale_r});
        mul_b = $signed({2'b0, life_left});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Divider step: restoring, one quotient bit a cycle.
  logic [32:0] div_sh, div_diff;
  logic        div_ge;
  logic [31:0] div_rem_nxt, div_q_nxt;

  assign div_sh      = {div_rem_r, div_q_r[31]};
  assign div_diff    = div_sh - {1'b0, div_d_r};
  assign div_ge      = (div_sh >= {1'b0, div_d_r});
  assign div_rem_nxt = div_ge ? div_diff[31:0] : div_sh[31:0];
  assign div_q_nxt   = {div_q_r[30:0], div_ge};

  // ---------------------------------------------------------------------------
  // Per-state arithmetic.
  logic [32:0]        credit_sum;
  logic [31:0]        credit_sat, interval_eff;
  logic [51:0]        jit_abs;
  logic [15:0]        jit_q0;
  logic [16:0]        jit_r0, jit_m;
  logic signed [17:0] jit_val;
  logic signed [51:0] prod_round, spawn_vx, spawn_vz, pos_sum;
  logic [32:0]        age_sum;
  logic [31:0]        age_new;
  particle_t          spawn_word;
  logic               keep_it, last_idx, scale_vis, out_free, out_load;
  logic [15:0]        scale_val;
  logic [CW-1:0]      kept_inc;

  // The credit sum is only taken when a tick is accepted, so it uses the incoming delta.
  assign credit_sum   = {1'b0, credit_r} + {16'b0, in_delta_time};
  assign credit_sat   = credit_sum[32] ? AGE_MAX : credit_sum[31:0];
  assign interval_eff = (cfg_interval_r == '0) ? 32'd1 : cfg_interval_r;

  // |p| / 65535 with p below 2^32: the first estimate is short by at most two.
  assign jit_abs = prod_r[51] ? 52'(-prod_r) : 52'(prod_r);
  assign jit_q0  = jit_abs[31:16];
  assign jit_r0  = {1'b0, jit_abs[15:0]} + {1'b0, jit_q0};
  assign jit_m   = {1'b0, jit_q0} + ((jit_r0 >= JIT_TWO) ? 17'd2 :
                                     (jit_r0 >= JIT_ONE) ? 17'd1 : 17'd0);
  assign jit_val = prod_r[51] ? -$signed({1'b0, jit_m}) : $signed({1'b0, jit_m});

  assign prod_round = round_q16(prod_r);
  assign spawn_vx   = 52'($signed(cfg_base_r[15:0])) + 52'(jx_r);
  assign spawn_vz   = 52'($signed(cfg_base_r[47:32])) + 52'(jz_r);
  assign pos_sum    = 52'($signed(wk_r.pos[k_r])) + prod_round;

  always_comb begin
    spawn_word.pos    = cfg_emit_r;
    spawn_word.vel[0] = sat16(spawn_vx);
    spawn_word.vel[1] = cfg_base_r[31:16];
    spawn_word.vel[2] = sat16(spawn_vz);
    spawn_word.age    = '0;
  end

  assign age_sum   = {1'b0, rd_data_r.age} + {16'b0, dt_r};
  assign age_new   = age_sum[32] ? AGE_MAX : age_sum[31:0];
  assign keep_it   = (wk_r.age < cfg_life_r);
  assign kept_inc  = kept_r + CW'(keep_it);
  assign last_idx  = (CW'(i_r + 1'b1) == alive_r);
  assign scale_val = div_q_r[15:0];
  assign scale_vis = (scale_val != '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_EOUT && scale_vis && pend_valid_r && out_free) ||
                     (state_r == S_FINAL && out_free);

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CDIV;
      S_CDIV:  if (div_cnt_r == 6'd1) state_nxt = S_DAMP;
      S_DAMP:  state_nxt = S_DAMP2;
      S_DAMP2: state_nxt = S_SPCHK;
      S_SPCHK: begin
        if (due_r != '0 && alive_r < CW'(MAX_PARTICLES)) begin
          state_nxt = S_JMUL;
        end else if (alive_r == '0) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_URD;
        end
      end
      S_JMUL:  state_nxt = S_JFIN;
      S_JFIN:  state_nxt = jsel_r ? S_SPWR : S_JMUL;
      S_SPWR:  state_nxt = S_SPCHK;
      S_URD:   state_nxt = S_ULD;
      S_ULD:   state_nxt = S_UM1;
      S_UM1:   state_nxt = S_UM2;
      S_UM2:   state_nxt = S_UM3;
      S_UM3:   state_nxt = (k_r == 2'd2) ? S_UWR : S_UM2;
      S_UWR: begin
        if (!last_idx) begin
          state_nxt = S_URD;
        end else if (kept_inc == '0) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_ERD:   state_nxt = S_EMUL;
      S_EMUL:  state_nxt = S_ELD;
      S_ELD:   state_nxt = S_EDIV;
      S_EDIV:  if (div_cnt_r == 6'd1) state_nxt = S_EOUT;
      S_EOUT: begin
        if (!(scale_vis && pend_valid_r && !out_free)) begin
          state_nxt = last_idx ? S_FINAL : S_ERD;
        end
      end
      S_FINAL: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Particle store: one write and one registered read a cycle.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  particle_t     mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kept_r[AW-1:0];
    mem_wdata = wk_r;
    if (state_r == S_SPWR) begin
      mem_we    = 1'b1;
      mem_waddr = alive_r[AW-1:0];
      mem_wdata = spawn_word;
    end else if (state_r == S_UWR && keep_it) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_r == S_URD) || (state_r == S_ERD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[i_r[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cfg_interval_r <= 32'd6554;
      cfg_life_r     <= 32'd196608;
      cfg_jitter_r   <= 16'd128;
      cfg_emit_r     <= 48'd0;
      cfg_base_r     <= 48'h0000_0100_0000;
      cfg_scale_r    <= 16'd256;
      rng_r          <= 32'd1;
      credit_r       <= '0;
      alive_r        <= '0;
      pend_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        unique case (reg_index_t'(cfg_index))
          REG_SPAWN_INTERVAL: cfg_interval_r <= cfg_wdata[31:0];
          REG_LIFETIME:       cfg_life_r     <= cfg_wdata[31:0];
          REG_VEL_JITTER:     cfg_jitter_r   <= cfg_wdata[15:0];
          REG_EMITTER_POS:    cfg_emit_r     <= cfg_wdata;
          REG_BASE_VEL:       cfg_base_r     <= cfg_wdata;
          REG_START_SCALE:    cfg_scale_r    <= cfg_wdata[15:0];
          REG_RANDOM_SEED:    rng_r <= (cfg_wdata[31:0] == '0) ? 32'd1 : cfg_wdata[31:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dt_r      <= in_delta_time;
            div_rem_r <= '0;
            div_q_r   <= credit_sat;
            div_d_r   <= interval_eff;
            div_cnt_r <= 6'(CREDIT_DIV_STEPS);
          end
        end
        S_CDIV: begin
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd1) begin
            credit_r <= div_rem_nxt;
            due_r    <= div_q_nxt;
          end
        end
        S_DAMP:  prod_r <= mul_p;
        S_DAMP2: damp_r <= 18'(52'sd65536 - prod_round);
        S_SPCHK: begin
          i_r    <= '0;
          kept_r <= '0;
          if (due_r != '0 && alive_r < CW'(MAX_PARTICLES)) begin
            rng_r  <= xorshift32(rng_r);
            jsel_r <= 1'b0;
          end
        end
        S_JMUL: prod_r <= mul_p;
        S_JFIN: begin
          if (!jsel_r) begin
            jx_r   <= jit_val;
            rng_r  <= xorshift32(rng_r);
            jsel_r <= 1'b1;
          end else begin
            jz_r <= jit_val;
          end
        end
        S_SPWR: begin
          alive_r <= alive_r + 1'b1;
          due_r   <= due_r - 32'd1;
        end
        S_URD: ;
        S_ULD: begin
          wk_r <= {rd_data_r.pos, rd_data_r.vel, age_new};
          k_r  <= 2'd0;
        end
        S_UM1: prod_r <= mul_p;
        S_UM2: begin
          wk_r.pos[k_r] <= sat16(pos_sum);
          prod_r        <= mul_p;
        end
        S_UM3: begin
          wk_r.vel[k_r] <= sat16(prod_round);
          prod_r        <= mul_p;
          if (k_r != 2'd2) begin
            k_r <= k_r + 2'd1;
          end
        end
        S_UWR: begin
          kept_r <= kept_inc;
          if (last_idx) begin
            alive_r <= kept_inc;
            i_r     <= '0;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_ERD: ;
        S_EMUL: prod_r <= mul_p;
        S_ELD: begin
          // The quotient is below 2^16, so the upper product bits are a valid
          // starting remainder.
          div_rem_r <= prod_r[47:16];
          div_q_r   <= {prod_r[15:0], 16'b0};
          div_d_r   <= cfg_life_r;
          div_cnt_r <= 6'(SCALE_DIV_STEPS);
        end
        S_EDIV: begin
          div_rem_r <= div_rem_nxt;
          div_q_r   <= div_q_nxt;
          div_cnt_r <= div_cnt_r - 6'd1;
        end
        S_EOUT: begin
          if (!(scale_vis && pend_valid_r && !out_free)) begin
            if (scale_vis) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_pos_r   <= pend_pos_r;
                out_scale_r <= pend_scale_r;
                out_live_r  <= 7'(alive_r);
                out_none_r  <= 1'b0;
                out_last_r  <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_pos_r   <= rd_data_r.pos;
              pend_scale_r <= scale_val;
            end
            i_r <= i_r + 1'b1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_live_r   <= 7'(alive_r);
            out_last_r   <= 1'b1;
            out_none_r   <= !pend_valid_r;
            out_pos_r    <= pend_valid_r ? pend_pos_r : '0;
            out_scale_r  <= pend_valid_r ? pend_scale_r : '0;
            pend_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_pos_x        = $signed(out_pos_r[0]);
  assign out_pos_y        = $signed(out_pos_r[1]);
  assign out_pos_z        = $signed(out_pos_r[2]);
  assign out_render_scale = out_scale_r;
  assign out_live_count   = out_live_r;
  assign out_none_visible = out_none_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  // The live count can never pass the store depth.
  a_alive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alive_r <= CW'(MAX_PARTICLES))
    else $error("live particle count exceeds store depth");

  // Compaction only ever writes at or behind the slot being read.
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UWR) |-> (kept_r <= i_r))
    else $error("compaction write index ran ahead of read index");

  // The divider remainder stays below the divisor while it iterates.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CDIV || state_r == S_EDIV) |-> (div_rem_r < div_d_r))
    else $error("divider remainder not below divisor");

  // No pending particle is carried from one tick into the next.
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("pending particle left over at end of tick");

  // Every tick ends with a word flagged last.
  a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINAL && out_free) |=> (out_valid_r && out_last_r))
    else $error("tick ended without a last word");
`endif

endmodule

/* tb/particle_emitter_step_checker.sv */
// Checker for the particle emitter step core: watches the tick, result and register
// channels, predicts the result words of every accepted tick and compares them. Depends on pes_pkg.
`timescale 1ns / 1ps

module particle_emitter_step_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [16:0] in_delta_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pos_x,
  input  logic [15:0] out_pos_y,
  input  logic [15:0] out_pos_z,
  input  logic [15:0] out_render_scale,
  input  logic [6:0]  out_live_count,
  input  logic        out_none_visible,
  input  logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  output int          fail_count,
  output int          pending_words,
  output int          word_total
);
  import pes_pkg::*;

  typedef struct packed {
    logic [15:0] px, py, pz, scale;
    logic [6:0]  live;
    logic        none, last;
  } frame_word_t;

  frame_word_t expected_words[$];

  logic [31:0] interval_q, life_q, seed_q, rng_q, credit_q;
  logic [15:0] jitter_q, scale0_q;
  logic [47:0] emit_q, basev_q;
  int          alive_q;
  longint      ppos[64][3];
  longint      pvel[64][3];
  logic [31:0] page[64];

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Floor division by 2^16 after adding half, exact for negative values.
  function automatic longint rnd16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic longint field16(logic [47:0] p, int k);
    logic signed [15:0] s;
    s = p[16*k +: 16];
    return longint'(s);
  endfunction

  function automatic longint next_jitter();
    longint t, p, m;
    rng_q = rng_q ^ (rng_q << 13);
    rng_q = rng_q ^ (rng_q >> 17);
    rng_q = rng_q ^ (rng_q << 5);
    t = 2 * longint'(rng_q[31:16]) - 65535;
    p = t * longint'(jitter_q);
    m = (p < 0 ? -p : p) / 65535;
    return p < 0 ? -m : m;
  endfunction

  task automatic predict_tick(logic [16:0] dt_in);
    longint unsigned credit, due, ivl, age, sc;
    longint dt, damp, v;
    int kept, nres;
    frame_word_t w;
    dt = dt_in;
    ivl = interval_q == 0 ? 1 : interval_q;
    credit = longint'(credit_q) + dt;
    if (credit > 64'hFFFF_FFFF) credit = 64'hFFFF_FFFF;
    due = credit / ivl;
    credit_q = 32'(credit - due * ivl);
    while (due > 0 && alive_q < 64) begin
      longint jx, jz;
      jx = next_jitter();
      jz = next_jitter();
      for (int k = 0; k < 3; k++) ppos[alive_q][k] = field16(emit_q, k);
      pvel[alive_q][0] = clamp16(field16(basev_q, 0) + jx);
      pvel[alive_q][1] = field16(basev_q, 1);
      pvel[alive_q][2] = clamp16(field16(basev_q, 2) + jz);
      page[alive_q] = 0;
      alive_q++;
      due--;
    end
    damp = 65536 - rnd16(39322 * dt);
    kept = 0;
    for (int i = 0; i < alive_q; i++) begin
      age = longint'(page[i]) + dt;
      page[i] = age > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : age[31:0];
      for (int k = 0; k < 3; k++) begin
        v = pvel[i][k];
        ppos[i][k] = clamp16(ppos[i][k] + rnd16(v * dt));
        pvel[i][k] = clamp16(rnd16(v * damp));
      end
      if (page[i] < life_q) begin
        ppos[kept] = ppos[i];
        pvel[kept] = pvel[i];
        page[kept] = page[i];
        kept++;
      end
    end
    alive_q = kept;
    nres = 0;
    for (int i = 0; i < alive_q; i++) begin
      sc = longint'(scale0_q) * (longint'(life_q) - longint'(page[i])) / longint'(life_q);
      if (sc != 0) begin
        w.px = ppos[i][0][15:0];
        w.py = ppos[i][1][15:0];
        w.pz = ppos[i][2][15:0];
        w.scale = sc[15:0];
        w.live = alive_q[6:0];
        w.none = 1'b0;
        w.last = 1'b0;
        expected_words.insert(expected_words.size(), w);
        nres++;
      end
    end
    if (nres == 0) begin
      w = '0;
      w.live = alive_q[6:0];
      w.none = 1'b1;
      w.last = 1'b1;
      expected_words.insert(expected_words.size(), w);
    end else begin
      expected_words[$].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    frame_word_t got, exp_w;
    if (!rst_n) begin
      interval_q <= 32'd6554;
      life_q     <= 32'd196608;
      jitter_q   <= 16'd128;
      emit_q     <= '0;
      basev_q    <= 48'h0000_0100_0000;
      scale0_q   <= 16'd256;
      seed_q     <= 32'd1;
      rng_q      <= 32'd1;
      credit_q   <= '0;
      alive_q    <= 0;
      fail_count <= 0;
      word_total <= 0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) begin
        case (reg_index_t'(cfg_index))
          REG_SPAWN_INTERVAL: interval_q = cfg_wdata[31:0];
          REG_LIFETIME:       life_q = cfg_wdata[31:0];
          REG_VEL_JITTER:     jitter_q = cfg_wdata[15:0];
          REG_EMITTER_POS:    emit_q = cfg_wdata;
          REG_BASE_VEL:       basev_q = cfg_wdata;
          REG_START_SCALE:    scale0_q = cfg_wdata[15:0];
          REG_RANDOM_SEED: begin
            seed_q = cfg_wdata[31:0];
            rng_q = seed_q == 0 ? 32'd1 : seed_q;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_pos_x, out_pos_y, out_pos_z, out_render_scale, out_live_count,
               out_none_visible, out_last};
        word_total <= word_total + 1;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            if (fail_count < 10)
              $display("ERROR: pos %0d/%0d/%0d scale %0d live %0d nv %b last %b, expected %0d/%0d/%0d scale %0d live %0d nv %b last %b",
                       $signed(got.px), $signed(got.py), $signed(got.pz), got.scale,
                       got.live, got.none, got.last, $signed(exp_w.px),
                       $signed(exp_w.py), $signed(exp_w.pz), exp_w.scale,
                       exp_w.live, exp_w.none, exp_w.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // The tick is predicted after any result of this edge has been taken off.
      if (in_valid && !in_stall) predict_tick(in_delta_time);
    end
    pending_words = expected_words.size();
  end
endmodule

/* tb/particle_emitter_step_core_tb.sv */
// Top of the particle emitter step testbench: clock, reset, register writes, tick
// stimulus and verdict. Depends on pes_pkg, the core and particle_emitter_step_checker.
`timescale 1ns / 1ps

module particle_emitter_step_core_tb;
  import pes_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [16:0] in_delta_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pos_x, out_pos_y, out_pos_z, out_render_scale;
  logic [6:0]  out_live_count;
  logic        out_none_visible, out_last;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_wdata = '0;
  int          fail_count, pending_words, word_total;
  int          tick_total;
  bit          calm_phase = 1'b0;
  bit          hold_receiver = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  particle_emitter_step_core uut (.*);

  particle_emitter_step_checker checker_i (.*);

  // Receiver: random stall bursts, a long hold-off when asked, none at the end.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
        hold_receiver = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [47:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_tick(logic [16:0] dt, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_delta_time <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tick_total++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // Wait on the clock first, so the checker has predicted the last accepted tick.
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [16:0] random_dt();
    case ($urandom_range(0, 5))
      0: return 17'($urandom_range(0, 131071));
      1: return 17'd65536;
      2: return 17'($urandom_range(0, 255));
      default: return 17'($urandom_range(500, 8000));
    endcase
  endfunction

  function automatic logic [47:0] random_vec();
    return 48'({$urandom, $urandom});
  endfunction

  initial begin
    tick_total = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: defaults, then field extremes and special cases.
    send_tick(17'd0, 0);
    send_tick(17'd6554, 0);
    send_tick(17'd65536, 0);
    send_tick(17'h1FFFF, 0);
    send_tick(17'd1, 0);
    drain();
    write_reg(REG_SPAWN_INTERVAL, 48'd0);   // behaves as one: fills the store
    write_reg(REG_RANDOM_SEED, 48'd0);
    write_reg(REG_VEL_JITTER, 48'hFFFF);
    write_reg(REG_BASE_VEL, 48'h7FFF_8000_7FFF);
    write_reg(REG_EMITTER_POS, 48'h8000_7FFF_8000);
    write_reg(REG_START_SCALE, 48'hFFFF);
    write_reg(REG_LIFETIME, 48'hFFFF_FFFF);
    send_tick(17'd100, 0);
    send_tick(17'h1FFFF, 0);
    send_tick(17'd65535, 0);
    drain();
    write_reg(REG_LIFETIME, 48'd1);         // everything expires at once
    write_reg(REG_SPAWN_INTERVAL, 48'hFFFF_FFFF);
    send_tick(17'd2, 0);
    drain();
    write_reg(REG_LIFETIME, 48'd0);
    send_tick(17'd0, 0);
    drain();
    write_reg(REG_START_SCALE, 48'd1);      // scale truncates to zero quickly
    write_reg(REG_LIFETIME, 48'd65536);
    write_reg(REG_SPAWN_INTERVAL, 48'd30000);
    send_tick(17'd40000, 0);
    send_tick(17'd200, 0);
    drain();

    // Random phases with fresh settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SPAWN_INTERVAL, ph == 5 ? 48'd1 : 48'($urandom_range(1500, 40000)));
      write_reg(REG_LIFETIME, ph == 4 ? 48'hFFFF_FFFF : 48'($urandom_range(30000, 400000)));
      write_reg(REG_VEL_JITTER, 48'($urandom_range(0, 65535)));
      write_reg(REG_EMITTER_POS, random_vec());
      write_reg(REG_BASE_VEL, ph == 0 ? 48'd0 : random_vec());
      write_reg(REG_START_SCALE, 48'($urandom_range(0, 65535)));
      write_reg(REG_RANDOM_SEED, 48'($urandom));
      if (ph == 2) hold_receiver = 1'b1;
      if (ph == 5) calm_phase = 1'b1;
      for (int i = 0; i < 42; i++) send_tick(random_dt(), !calm_phase);
      drain();
    end

    $display("Run covered %0d ticks and %0d result words over directed corner settings",
             tick_total, word_total);
    $display("and six random ones, with a full store, total expiry and a long hold-off.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
